// ===== rtl/cswl_pkg.sv =====
// ----------------------------------------------------------------------------
// cswl_pkg
// shared types, byte codes and the byte classifier of the comment stripper
// ----------------------------------------------------------------------------
package cswl_pkg;

    localparam int MAX_DELIM_DEF  = 17;
    localparam int HOLD_DEPTH_DEF = 24;
    localparam int FIFO_DEPTH     = 4;

    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_NL     = 8'h0a;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VT     = 8'h0b;
    localparam logic [7:0] CH_FF     = 8'h0c;
    localparam logic [7:0] CH_CR     = 8'h0d;

    typedef enum logic [3:0] {
        CL_OTHER,
        CL_SLASH,
        CL_STAR,
        CL_DQUOTE,
        CL_SQUOTE,
        CL_R,
        CL_LPAREN,
        CL_RPAREN,
        CL_BSLASH,
        CL_NEWLINE,
        CL_SPACE
    } t_cls;

    typedef enum logic [2:0] {
        M_NORMAL,
        M_SLASH,
        M_OPEN,
        M_BLOCK,
        M_LINE,
        M_STR,
        M_CHR,
        M_RAW
    } t_mode;

    typedef enum logic [2:0] {
        PH_SCAN,
        PH_HOLD,
        PH_CLOSE,
        PH_QUOTE,
        PH_FIN
    } t_phase;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        t_cls       cls;
    } t_word;

    function automatic t_cls classify(input logic [7:0] b);
        t_cls c;
        case (b)
            CH_SLASH:  c = CL_SLASH;
            CH_STAR:   c = CL_STAR;
            CH_DQUOTE: c = CL_DQUOTE;
            CH_SQUOTE: c = CL_SQUOTE;
            CH_R:      c = CL_R;
            CH_LPAREN: c = CL_LPAREN;
            CH_RPAREN: c = CL_RPAREN;
            CH_BSLASH: c = CL_BSLASH;
            CH_NL:     c = CL_NEWLINE;
            CH_SPACE:  c = CL_SPACE;
            CH_TAB:    c = CL_SPACE;
            CH_VT:     c = CL_SPACE;
            CH_FF:     c = CL_SPACE;
            CH_CR:     c = CL_SPACE;
            default:   c = CL_OTHER;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/cswl_front.sv =====
// ----------------------------------------------------------------------------
// cswl_front
// input side: takes words, classifies each byte and queues it for the scanner
// ----------------------------------------------------------------------------
module cswl_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic [7:0]      i_in_byte,
    input  logic            i_in_last,
    output logic            o_head_valid,
    output cswl_pkg::t_word o_head,
    input  logic            i_pop
);

    localparam int FAW = $clog2(cswl_pkg::FIFO_DEPTH);
    localparam int FCW = $clog2(cswl_pkg::FIFO_DEPTH + 1);

    cswl_pkg::t_word r_mem [cswl_pkg::FIFO_DEPTH];
    logic [FAW-1:0]  r_wp, n_wp;
    logic [FAW-1:0]  r_rp, n_rp;
    logic [FCW-1:0]  r_cnt, n_cnt;
    logic            push;
    logic            pop;
    cswl_pkg::t_word wr_word;

    assign o_in_stall   = (r_cnt == FCW'(cswl_pkg::FIFO_DEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_mem[r_rp];

    always_comb begin
        push         = i_in_valid && !o_in_stall;
        pop          = i_pop && o_head_valid;
        wr_word.data = i_in_byte;
        wr_word.last = i_in_last;
        wr_word.cls  = cswl_pkg::classify(i_in_byte);
        n_wp         = push ? FAW'(r_wp + 1'b1) : r_wp;
        n_rp         = pop ? FAW'(r_rp + 1'b1) : r_rp;
        n_cnt        = r_cnt;
        if (push && !pop) begin
            n_cnt = FCW'(r_cnt + 1'b1);
        end else if (pop && !push) begin
            n_cnt = FCW'(r_cnt - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= wr_word;
        end
    end

endmodule

// ===== rtl/cswl_back.sv =====
// ----------------------------------------------------------------------------
// cswl_back
// scanner: runs the comment and literal rules one word at a time, keeps the
// raw opening window for replay and drives the output word register
// ----------------------------------------------------------------------------
module cswl_back #(
    parameter int MAX_DELIM  = cswl_pkg::MAX_DELIM_DEF,
    parameter int HOLD_DEPTH = cswl_pkg::HOLD_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_head_valid,
    input  cswl_pkg::t_word i_head,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_run_last
);

    localparam int DELIM_LIMIT = (MAX_DELIM < HOLD_DEPTH - 4) ? MAX_DELIM : HOLD_DEPTH - 4;
    localparam int RB_AW       = $clog2(HOLD_DEPTH);
    localparam int RB_DEPTH    = 1 << RB_AW;
    localparam int DIW         = (MAX_DELIM > 1) ? $clog2(MAX_DELIM) : 1;
    localparam int CW          = $clog2(MAX_DELIM + 2);

    typedef struct packed {
        logic [7:0]     data;
        cswl_pkg::t_cls cls;
    } t_rbent;

    t_rbent      r_rb [RB_DEPTH];
    logic [7:0]  r_delim [MAX_DELIM];

    cswl_pkg::t_mode  r_mode, n_mode;
    cswl_pkg::t_phase r_phase, n_phase;
    logic             r_esc, n_esc;
    logic [CW-1:0]    r_dl, n_dl;
    logic [CW-1:0]    r_cm, n_cm;
    logic [CW-1:0]    r_idx, n_idx;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [RB_AW-1:0] r_hc, n_hc;
    logic [RB_AW-1:0] r_hi, n_hi;
    logic [RB_AW-1:0] r_s, n_s;
    logic [RB_AW-1:0] r_rp, n_rp;
    logic [RB_AW-1:0] r_n, n_n;
    logic [RB_AW-1:0] r_rtpos, n_rtpos;
    t_rbent           r_rt, n_rt;
    logic             r_retry, n_retry;
    logic             r_close, n_close;
    logic             r_after, n_after;
    logic             r_busy, n_busy;
    logic             r_lastf, n_lastf;
    logic             r_pv, n_pv;
    logic [7:0]       r_pb, n_pb;
    logic             r_ov, n_ov;
    logic [7:0]       r_ob, n_ob;
    logic             r_ol, n_ol;

    logic             go;
    logic             out_free;
    logic             em;
    logic [7:0]       em_b;
    logic             fin_push;
    logic             have;
    t_rbent           ent;
    logic [RB_AW-1:0] cur_pos;
    logic [RB_AW-1:0] rb_addr;
    t_rbent           rb_rd;
    logic [CW-1:0]    k;
    logic [CW-1:0]    dl_addr;
    logic [7:0]       dl_rd;
    logic             we_rb;
    t_rbent           rb_wdata;
    logic             we_dl;

    assign out_free    = !r_ov || !i_out_stall;
    assign go          = !r_pv || out_free;
    assign k           = CW'(r_cm - 1'b1);
    assign rb_addr     = (r_phase == cswl_pkg::PH_HOLD) ? RB_AW'(r_s + r_hi) : r_rp;
    assign rb_rd       = r_rb[rb_addr];
    assign dl_addr     = (r_phase == cswl_pkg::PH_CLOSE) ? CW'(r_idx - 1'b1) : k;
    assign dl_rd       = r_delim[dl_addr[DIW-1:0]];
    assign o_out_valid = r_ov;
    assign o_out_byte  = r_ob;
    assign o_run_last  = r_ol;

    always_comb begin
        n_mode   = r_mode;
        n_phase  = r_phase;
        n_esc    = r_esc;
        n_dl     = r_dl;
        n_cm     = r_cm;
        n_idx    = r_idx;
        n_cnt    = r_cnt;
        n_hc     = r_hc;
        n_hi     = r_hi;
        n_s      = r_s;
        n_rp     = r_rp;
        n_n      = r_n;
        n_rtpos  = r_rtpos;
        n_rt     = r_rt;
        n_retry  = r_retry;
        n_close  = r_close;
        n_after  = r_after;
        n_busy   = r_busy;
        n_lastf  = r_lastf;
        em       = 1'b0;
        em_b     = '0;
        fin_push = 1'b0;
        have     = 1'b0;
        ent      = r_rt;
        cur_pos  = r_rp;
        o_pop    = 1'b0;
        we_rb    = 1'b0;
        rb_wdata = '{data: i_head.data, cls: i_head.cls};
        we_dl    = 1'b0;

        if (go) begin
            case (r_phase)
                cswl_pkg::PH_SCAN: begin
                    if (r_retry) begin
                        have    = 1'b1;
                        ent     = r_rt;
                        cur_pos = r_rtpos;
                        n_retry = 1'b0;
                    end else if (r_rp != r_n) begin
                        have    = 1'b1;
                        ent     = rb_rd;
                        cur_pos = r_rp;
                        n_rp    = RB_AW'(r_rp + 1'b1);
                    end else if (!r_busy) begin
                        if (i_head_valid) begin
                            have    = 1'b1;
                            o_pop   = 1'b1;
                            ent     = rb_wdata;
                            cur_pos = r_rp;
                            n_busy  = 1'b1;
                            n_lastf = i_head.last;
                            we_rb   = 1'b1;
                            n_n     = RB_AW'(r_n + 1'b1);
                            n_rp    = RB_AW'(r_rp + 1'b1);
                        end
                    end else begin
                        // end of the step: flush at the end of the text
                        if (r_lastf && r_mode == cswl_pkg::M_OPEN) begin
                            em     = 1'b1;
                            em_b   = cswl_pkg::CH_R;
                            n_rp   = RB_AW'(r_s + 1'b1);
                            n_mode = cswl_pkg::M_NORMAL;
                            n_hc   = '0;
                        end else if (r_lastf && r_mode == cswl_pkg::M_SLASH) begin
                            em      = 1'b1;
                            em_b    = cswl_pkg::CH_SLASH;
                            n_phase = cswl_pkg::PH_FIN;
                        end else if (r_lastf && r_mode == cswl_pkg::M_RAW && r_cm != '0) begin
                            n_phase = cswl_pkg::PH_CLOSE;
                            n_idx   = '0;
                            n_cnt   = k;
                            n_close = 1'b0;
                            n_after = 1'b1;
                        end else begin
                            n_phase = cswl_pkg::PH_FIN;
                        end
                    end

                    if (have) begin
                        case (r_mode)
                            cswl_pkg::M_NORMAL: begin
                                if (ent.cls == cswl_pkg::CL_R) begin
                                    n_s    = cur_pos;
                                    n_hc   = RB_AW'(1);
                                    n_dl   = '0;
                                    n_mode = cswl_pkg::M_OPEN;
                                end else if (ent.cls == cswl_pkg::CL_SLASH) begin
                                    n_mode = cswl_pkg::M_SLASH;
                                end else begin
                                    em   = 1'b1;
                                    em_b = ent.data;
                                    if (ent.cls == cswl_pkg::CL_DQUOTE) begin
                                        n_mode = cswl_pkg::M_STR;
                                        n_esc  = 1'b0;
                                    end else if (ent.cls == cswl_pkg::CL_SQUOTE) begin
                                        n_mode = cswl_pkg::M_CHR;
                                        n_esc  = 1'b0;
                                    end
                                end
                            end
                            cswl_pkg::M_SLASH: begin
                                if (ent.cls == cswl_pkg::CL_STAR) begin
                                    n_mode = cswl_pkg::M_BLOCK;
                                    n_esc  = 1'b0;
                                end else if (ent.cls == cswl_pkg::CL_SLASH) begin
                                    n_mode = cswl_pkg::M_LINE;
                                end else begin
                                    em      = 1'b1;
                                    em_b    = cswl_pkg::CH_SLASH;
                                    n_mode  = cswl_pkg::M_NORMAL;
                                    n_retry = 1'b1;
                                    n_rt    = ent;
                                    n_rtpos = cur_pos;
                                end
                            end
                            cswl_pkg::M_OPEN: begin
                                if (r_hc < RB_AW'(2)) begin
                                    if (ent.cls == cswl_pkg::CL_DQUOTE) begin
                                        n_hc = RB_AW'(2);
                                    end else begin
                                        em     = 1'b1;
                                        em_b   = cswl_pkg::CH_R;
                                        n_rp   = RB_AW'(r_s + 1'b1);
                                        n_mode = cswl_pkg::M_NORMAL;
                                        n_hc   = '0;
                                    end
                                end else if (ent.cls == cswl_pkg::CL_LPAREN) begin
                                    n_phase = cswl_pkg::PH_HOLD;
                                    n_hi    = '0;
                                end else if (ent.cls == cswl_pkg::CL_RPAREN
                                        || ent.cls == cswl_pkg::CL_BSLASH
                                        || ent.cls == cswl_pkg::CL_SPACE
                                        || ent.cls == cswl_pkg::CL_NEWLINE
                                        || r_dl >= CW'(DELIM_LIMIT)) begin
                                    em     = 1'b1;
                                    em_b   = cswl_pkg::CH_R;
                                    n_rp   = RB_AW'(r_s + 1'b1);
                                    n_mode = cswl_pkg::M_NORMAL;
                                    n_hc   = '0;
                                end else begin
                                    we_dl = 1'b1;
                                    n_dl  = CW'(r_dl + 1'b1);
                                    n_hc  = RB_AW'(r_hc + 1'b1);
                                end
                            end
                            cswl_pkg::M_BLOCK: begin
                                if (r_esc && ent.cls == cswl_pkg::CL_SLASH) begin
                                    n_mode = cswl_pkg::M_NORMAL;
                                    n_esc  = 1'b0;
                                end else begin
                                    n_esc = (ent.cls == cswl_pkg::CL_STAR);
                                end
                            end
                            cswl_pkg::M_LINE: begin
                                if (ent.cls == cswl_pkg::CL_NEWLINE) begin
                                    em     = 1'b1;
                                    em_b   = ent.data;
                                    n_mode = cswl_pkg::M_NORMAL;
                                end
                            end
                            cswl_pkg::M_STR, cswl_pkg::M_CHR: begin
                                em   = 1'b1;
                                em_b = ent.data;
                                if (r_esc) begin
                                    n_esc = 1'b0;
                                end else if (ent.cls == cswl_pkg::CL_BSLASH) begin
                                    n_esc = 1'b1;
                                end else if ((r_mode == cswl_pkg::M_STR
                                              && ent.cls == cswl_pkg::CL_DQUOTE)
                                          || (r_mode == cswl_pkg::M_CHR
                                              && ent.cls == cswl_pkg::CL_SQUOTE)) begin
                                    n_mode = cswl_pkg::M_NORMAL;
                                end
                            end
                            default: begin
                                if (r_cm == '0) begin
                                    if (ent.cls == cswl_pkg::CL_RPAREN) begin
                                        n_cm = CW'(1);
                                    end else begin
                                        em   = 1'b1;
                                        em_b = ent.data;
                                    end
                                end else if (k < r_dl && ent.data == dl_rd) begin
                                    n_cm = CW'(r_cm + 1'b1);
                                end else if (k == r_dl && ent.cls == cswl_pkg::CL_DQUOTE) begin
                                    n_cm    = '0;
                                    n_phase = cswl_pkg::PH_CLOSE;
                                    n_idx   = '0;
                                    n_cnt   = k;
                                    n_close = 1'b1;
                                    n_after = 1'b0;
                                end else begin
                                    n_cm    = '0;
                                    n_phase = cswl_pkg::PH_CLOSE;
                                    n_idx   = '0;
                                    n_cnt   = k;
                                    n_close = 1'b0;
                                    n_after = 1'b0;
                                    n_rt    = ent;
                                    n_rtpos = cur_pos;
                                end
                            end
                        endcase
                    end
                end
                cswl_pkg::PH_HOLD: begin
                    em = 1'b1;
                    if (r_hi < r_hc) begin
                        em_b = rb_rd.data;
                        n_hi = RB_AW'(r_hi + 1'b1);
                    end else begin
                        em_b    = cswl_pkg::CH_LPAREN;
                        n_mode  = cswl_pkg::M_RAW;
                        n_hc    = '0;
                        n_cm    = '0;
                        n_phase = cswl_pkg::PH_SCAN;
                    end
                end
                cswl_pkg::PH_CLOSE: begin
                    em   = 1'b1;
                    em_b = (r_idx == '0) ? cswl_pkg::CH_RPAREN : dl_rd;
                    if (r_idx == r_cnt) begin
                        if (r_close) begin
                            n_phase = cswl_pkg::PH_QUOTE;
                        end else if (r_after) begin
                            n_phase = cswl_pkg::PH_FIN;
                        end else begin
                            n_retry = 1'b1;
                            n_phase = cswl_pkg::PH_SCAN;
                        end
                    end else begin
                        n_idx = CW'(r_idx + 1'b1);
                    end
                end
                cswl_pkg::PH_QUOTE: begin
                    em      = 1'b1;
                    em_b    = cswl_pkg::CH_DQUOTE;
                    n_mode  = cswl_pkg::M_NORMAL;
                    n_phase = cswl_pkg::PH_SCAN;
                end
                cswl_pkg::PH_FIN: begin
                    fin_push = r_pv;
                    n_busy   = 1'b0;
                    n_phase  = cswl_pkg::PH_SCAN;
                    if (r_lastf) begin
                        n_mode  = cswl_pkg::M_NORMAL;
                        n_esc   = 1'b0;
                        n_dl    = '0;
                        n_cm    = '0;
                        n_hc    = '0;
                        n_lastf = 1'b0;
                    end
                end
                default: begin
                    n_phase = cswl_pkg::PH_SCAN;
                end
            endcase
        end

        // pending word goes out once the next one shows up or the step ends
        n_pv = r_pv;
        n_pb = r_pb;
        n_ov = out_free ? 1'b0 : r_ov;
        n_ob = r_ob;
        n_ol = r_ol;
        if (em) begin
            if (r_pv) begin
                n_ov = 1'b1;
                n_ob = r_pb;
                n_ol = 1'b0;
            end
            n_pv = 1'b1;
            n_pb = em_b;
        end else if (fin_push) begin
            n_ov = 1'b1;
            n_ob = r_pb;
            n_ol = 1'b1;
            n_pv = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= cswl_pkg::M_NORMAL;
            r_phase <= cswl_pkg::PH_SCAN;
            r_esc   <= 1'b0;
            r_dl    <= '0;
            r_cm    <= '0;
            r_hc    <= '0;
            r_hi    <= '0;
            r_s     <= '0;
            r_rp    <= '0;
            r_n     <= '0;
            r_retry <= 1'b0;
            r_close <= 1'b0;
            r_after <= 1'b0;
            r_busy  <= 1'b0;
            r_lastf <= 1'b0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
            r_ol    <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_phase <= n_phase;
            r_esc   <= n_esc;
            r_dl    <= n_dl;
            r_cm    <= n_cm;
            r_hc    <= n_hc;
            r_hi    <= n_hi;
            r_s     <= n_s;
            r_rp    <= n_rp;
            r_n     <= n_n;
            r_retry <= n_retry;
            r_close <= n_close;
            r_after <= n_after;
            r_busy  <= n_busy;
            r_lastf <= n_lastf;
            r_pv    <= n_pv;
            r_ov    <= n_ov;
            r_ol    <= n_ol;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_cnt   <= n_cnt;
        r_rt    <= n_rt;
        r_rtpos <= n_rtpos;
        r_pb    <= n_pb;
        r_ob    <= n_ob;
    end

    always_ff @(posedge i_clk) begin
        if (we_rb) begin
            r_rb[r_n] <= rb_wdata;
        end
        if (we_dl) begin
            r_delim[r_dl[DIW-1:0]] <= ent.data;
        end
    end

    a_phase_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != cswl_pkg::PH_SCAN |-> r_busy)
        else $error("emit sequence outside a step");

    a_open_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == cswl_pkg::M_OPEN |-> (r_hc != '0
            && r_hc <= RB_AW'(DELIM_LIMIT + 2)))
        else $error("raw opening window out of range");

    a_close_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cm <= CW'(r_dl + 1'b1))
        else $error("close candidate beyond delimiter");

    a_fin_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == cswl_pkg::PH_FIN && go) |=> !r_busy && !r_pv)
        else $error("step end left work pending");

endmodule

// ===== rtl/comment_stripper_with_literals_top.sv =====
// ----------------------------------------------------------------------------
// comment_stripper_with_literals_top
// strips C++ block and line comments, keeping string, char and raw literals
// ----------------------------------------------------------------------------
// input channel: one source byte per word with i_in_last on the final byte;
// a word is taken when i_in_valid is high and o_in_stall is low.
// output channel: zero or more bytes per input word; o_run_last marks the
// last byte caused by one input word, o_out_valid/i_out_stall handshake.
// a four-word queue decouples input from the scanner, which takes a word,
// scans it, checks for the end of the step and then closes the step
// before it takes the next word.
// emitting a held raw opening, a close candidate or replaying a failed
// raw opening holds the scanner while those bytes are sent or rescanned one at a time.
// a plain byte waits as the pending word until its step closes, then is
// registered out. reset (synchronous, active low) empties the queue and
// returns the scanner to plain text. i_out_stall holds the output word and
// the scanner, and the input queue fills and raises o_in_stall.
// after the word marked last all scanner state returns to plain text.
// ----------------------------------------------------------------------------
module comment_stripper_with_literals_top #(
    parameter int MAX_DELIM  = cswl_pkg::MAX_DELIM_DEF,
    parameter int HOLD_DEPTH = cswl_pkg::HOLD_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_run_last
);

    logic            head_valid;
    cswl_pkg::t_word head;
    logic            pop;

    cswl_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_byte    (i_in_byte),
        .i_in_last    (i_in_last),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    cswl_back #(
        .MAX_DELIM  (MAX_DELIM),
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_byte   (o_out_byte),
        .o_run_last   (o_run_last)
    );

endmodule
